FILE: hdl/sha1_hash_core_assert.svh
// Assertion macros shared by the SHA-1 core modules.
`ifndef SHA1_HASH_CORE_ASSERT_SVH
`define SHA1_HASH_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SHA1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SHA1_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hdl/sha1_pkg.sv
// Types and constants shared by the SHA-1 core modules.
`timescale 1ns / 1ps
package sha1_pkg;

  localparam int ActionW = 2;
  localparam int ByteW   = 8;
  localparam int WordW   = 32;
  localparam int IndexW  = 3;
  localparam int CountW  = 61;
  localparam int LenW    = 64;
  localparam int FillW   = 6;
  localparam int RoundW  = 7;
  localparam int BlockW  = 512;

  // Action codes on the input channel.
  localparam logic [ActionW-1:0] ActAppend       = 2'd0;
  localparam logic [ActionW-1:0] ActAppendFinish = 2'd1;

  // Initial chaining value H0..H4.
  localparam logic [0:4][WordW-1:0] InitH = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Round constants, one per group of 20 rounds.
  localparam logic [WordW-1:0] K0 = 32'h5a827999;
  localparam logic [WordW-1:0] K1 = 32'h6ed9eba1;
  localparam logic [WordW-1:0] K2 = 32'h8f1bbcdc;
  localparam logic [WordW-1:0] K3 = 32'hca62c1d6;

  localparam logic [ByteW-1:0]  PadByte     = 8'h80;
  localparam logic [FillW-1:0]  FillLast    = 6'd63;
  localparam logic [FillW-1:0]  FillLenPos  = 6'd56;
  localparam logic [RoundW-1:0] RoundLast   = 7'd79;
  localparam logic [IndexW-1:0] IndexLast   = 3'd4;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_APPEND_FINISH,
    CMD_FINISH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hdl/sha1_if.sv
// Request and digest channel interfaces of the SHA-1 core.
`timescale 1ns / 1ps
interface sha1_in_if;
  logic                         valid;
  logic                         ready;
  logic [sha1_pkg::ActionW-1:0] action;
  logic [sha1_pkg::ByteW-1:0]   data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface sha1_out_if;
  logic                        valid;
  logic                        ready;
  logic [sha1_pkg::WordW-1:0]  digest_word;
  logic [sha1_pkg::IndexW-1:0] word_index;
  logic                        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: hdl/sha1_front.sv
// Front end: accepts requests and classifies them into engine commands.
`timescale 1ns / 1ps
module sha1_front (
  sha1_in_if.sink           in_i,
  input  sha1_pkg::q_stat_t stat_i,
  output logic              push_o,
  output sha1_pkg::cmd_t    cmd_o
);

  // Take a request whenever the queue has room.
  assign in_i.ready = !stat_i.full;
  assign push_o     = in_i.valid && !stat_i.full;

  // Decode the action; every other code is a plain finish.
  always_comb begin
    cmd_o.data = in_i.data_byte;
    unique case (in_i.action)
      sha1_pkg::ActAppend:       cmd_o.kind = sha1_pkg::CMD_APPEND;
      sha1_pkg::ActAppendFinish: cmd_o.kind = sha1_pkg::CMD_APPEND_FINISH;
      default:                   cmd_o.kind = sha1_pkg::CMD_FINISH;
    endcase
  end

endmodule

FILE: hdl/sha1_queue.sv
// Command queue between the front end and the hash engine.
`timescale 1ns / 1ps
module sha1_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sha1_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output sha1_pkg::cmd_t    cmd_o,
  output sha1_pkg::q_stat_t stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  sha1_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`include "sha1_hash_core_assert.svh"

  `SHA1_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntFull, "queue count beyond depth")
  `SHA1_ASSERT(a_no_push_full, push_i |-> !stat_o.full, "push while queue full")
  `SHA1_ASSERT(a_push_fills, (do_push && !do_pop) |=> !stat_o.empty, "push lost")

endmodule

FILE: hdl/sha1_engine.sv
// Hash engine: packs bytes, pads, runs the compression rounds, emits the digest.
`timescale 1ns / 1ps
module sha1_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1_pkg::cmd_t    cmd_i,
  input  sha1_pkg::q_stat_t stat_i,
  output logic              pop_o,
  sha1_out_if.source        out_o
);

  localparam int WordW = sha1_pkg::WordW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_e;

  state_e                             state_q, state_d, ret_q, ret_d;
  logic [sha1_pkg::FillW-1:0]         fill_q, fill_d;
  logic [sha1_pkg::CountW-1:0]        count_q, count_d;
  logic [0:4][WordW-1:0]              chain_q, chain_d;
  logic                               first_q, first_d;
  logic                               room_q, room_d;
  logic [sha1_pkg::RoundW-1:0]        rnd_q, rnd_d;
  logic [sha1_pkg::IndexW-1:0]        idx_q, idx_d;
  logic                               out_valid_q, out_valid_d;

  logic [sha1_pkg::BlockW-1:0]        blk_q, blk_d;
  logic [sha1_pkg::LenW-1:0]          len_q, len_d;
  logic [WordW-1:0]                   a_q, b_q, c_q, d_q, e_q;
  logic [WordW-1:0]                   a_d, b_d, c_d, d_d, e_d;
  logic [WordW-1:0]                   digest_q, digest_d;
  logic [sha1_pkg::IndexW-1:0]        index_q, index_d;
  logic                               last_q, last_d;

  logic [WordW-1:0]                   w0, wx, wnew, f, k, tmp;
  logic [sha1_pkg::ByteW-1:0]         pad_byte;
  logic                               fin, takes_byte, len_phase, room_now, emit_load;

  // Message schedule taps on the block shift line.
  assign w0   = blk_q[511:480];
  assign wx   = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
  assign wnew = {wx[WordW-2:0], wx[WordW-1]};

  // Round function and constant by round group.
  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = sha1_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = sha1_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = sha1_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = sha1_pkg::K3;
    end
  end

  assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + w0 + k;

  // Padding byte: marker first, then zeros, then the bit length in the final block.
  assign len_phase = !first_q && room_q && (fill_q >= sha1_pkg::FillLenPos);
  assign room_now  = first_q ? (fill_q < sha1_pkg::FillLenPos) : room_q;
  assign pad_byte  = first_q   ? sha1_pkg::PadByte :
                     len_phase ? len_q[63:56] : '0;

  assign fin        = (cmd_i.kind != sha1_pkg::CMD_APPEND);
  assign takes_byte = (cmd_i.kind != sha1_pkg::CMD_FINISH);
  assign emit_load  = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fill_d      = fill_q;
    count_d     = count_q;
    chain_d     = chain_q;
    first_d     = first_q;
    room_d      = room_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    blk_d       = blk_q;
    len_d       = len_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    e_d         = e_q;
    digest_d    = digest_q;
    index_d     = index_q;
    last_d      = last_q;
    pop_o       = 1'b0;

    unique case (state_q)
      // Take the next command from the queue.
      ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o = 1'b1;
          if (takes_byte) begin
            blk_d   = {blk_q[503:0], cmd_i.data};
            fill_d  = fill_q + 1'b1;
            count_d = count_q + 1'b1;
          end
          if (fin) begin
            len_d   = {count_d, 3'b000};
            first_d = 1'b1;
          end
          if (takes_byte && fill_q == sha1_pkg::FillLast) begin
            state_d = ST_ROUND;
            ret_d   = fin ? ST_PAD : ST_IDLE;
            rnd_d   = '0;
            a_d     = chain_q[0];
            b_d     = chain_q[1];
            c_d     = chain_q[2];
            d_d     = chain_q[3];
            e_d     = chain_q[4];
          end else if (fin) begin
            state_d = ST_PAD;
          end
        end
      end

      // One compression round per cycle.
      ST_ROUND: begin
        a_d   = tmp;
        b_d   = a_q;
        c_d   = {b_q[1:0], b_q[31:2]};
        d_d   = c_q;
        e_d   = d_q;
        blk_d = {blk_q[479:0], wnew};
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == sha1_pkg::RoundLast) begin
          state_d = ST_ADD;
        end
      end

      // Fold the working variables into the chaining value.
      ST_ADD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
        idx_d      = '0;
        state_d    = ret_q;
      end

      // Shift in one padding byte per cycle.
      ST_PAD: begin
        blk_d   = {blk_q[503:0], pad_byte};
        fill_d  = fill_q + 1'b1;
        first_d = 1'b0;
        if (first_q) begin
          room_d = room_now;
        end
        if (len_phase) begin
          len_d = {len_q[55:0], 8'h00};
        end
        if (fill_q == sha1_pkg::FillLast) begin
          state_d = ST_ROUND;
          ret_d   = room_now ? ST_EMIT : ST_PAD;
          room_d  = 1'b1;
          rnd_d   = '0;
          a_d     = chain_q[0];
          b_d     = chain_q[1];
          c_d     = chain_q[2];
          d_d     = chain_q[3];
          e_d     = chain_q[4];
        end
      end

      // Hand out the digest words, then restart for the next message.
      ST_EMIT: begin
        if (emit_load) begin
          out_valid_d = 1'b1;
          digest_d    = chain_q[idx_q];
          index_d     = idx_q;
          last_d      = (idx_q == sha1_pkg::IndexLast);
          idx_d       = idx_q + 1'b1;
          if (idx_q == sha1_pkg::IndexLast) begin
            chain_d = sha1_pkg::InitH;
            count_d = '0;
            idx_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      fill_q      <= '0;
      count_q     <= '0;
      chain_q     <= sha1_pkg::InitH;
      first_q     <= 1'b0;
      room_q      <= 1'b0;
      rnd_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      chain_q     <= chain_d;
      first_q     <= first_d;
      room_q      <= room_d;
      rnd_q       <= rnd_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    len_q    <= len_d;
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    d_q      <= d_d;
    e_q      <= e_d;
    digest_q <= digest_d;
    index_q  <= index_d;
    last_q   <= last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digest_word = digest_q;
  assign out_o.word_index  = index_q;
  assign out_o.last_word   = last_q;

`include "sha1_hash_core_assert.svh"

  `SHA1_ASSERT(a_last_idx, out_valid_q |-> (last_q == (index_q == sha1_pkg::IndexLast)),
    "last flag disagrees with word index")
  `SHA1_ASSERT(a_rnd_bound, (state_q == ST_ROUND) |-> (rnd_q <= sha1_pkg::RoundLast),
    "round counter out of range")
  `SHA1_ASSERT(a_blk_full, (state_q == ST_ROUND) |-> (fill_q == '0),
    "compression started on a partial block")
  `SHA1_ASSERT(a_restart,
    (state_q == ST_EMIT && emit_load && idx_q == sha1_pkg::IndexLast) |=>
    (state_q == ST_IDLE && count_q == '0 && fill_q == '0),
    "engine did not restart after the digest")

endmodule

FILE: hdl/sha1_hash_core.sv
// A request is stored in the queue when it is accepted; the engine pops it while idle
// and shifts its byte into the block. Every 64th byte starts a compression of 80 rounds
// plus the chaining add. A finish shifts padding one byte per cycle up to the next
// block end, compresses once or twice, then hands out 5 digest words one per cycle
// while out_o is ready. The single round unit sets throughput; no pops while it runs.
// Reset (async, active low) empties the queue and loads the initial chaining value.
`timescale 1ns / 1ps
module sha1_hash_core #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_in_if.sink    in_i,
  sha1_out_if.source out_o
);

  logic              push, pop;
  sha1_pkg::cmd_t    push_cmd, head_cmd;
  sha1_pkg::q_stat_t q_stat;

  sha1_front u_front (
    .in_i   (in_i),
    .stat_i (q_stat),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  sha1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  sha1_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (head_cmd),
    .stat_i (q_stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the SHA-1 hash core: byte requests in, digest words out.
`timescale 1ns / 1ps
module tb;

  // Action code 3 is unused and decodes like a finish without a byte
  localparam logic [1:0] ActUnused    = 2'd3;
  localparam int         SettleCycles = 300;
  localparam int         DigestWords  = 5;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sha1_in_if  req_if ();
  sha1_out_if dig_if ();

  sha1_hash_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (dig_if)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Running hash state mirrored from the request stream
  logic [31:0]  chain_h [5];
  logic [31:0]  msg_blk [16];
  logic [60:0]  msg_len;
  logic [5:0]   blk_fill;
  digest_word_t digest_q [$];

  int  fail_count     = 0;
  int  requests_sent  = 0;
  int  messages_done  = 0;
  int  words_checked  = 0;
  int  hold_request   = 0;
  bit  src_gaps_on    = 1'b1;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Run the 80 rounds on the current block and fold into the chaining value
  function automatic void compress_blk();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = msg_blk[i];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      t = rotl(a, 5) + f + e + w[r % 16] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Bytes go into the block big-endian within each word
  function automatic void place_byte(input int unsigned pos, input logic [7:0] v);
    msg_blk[pos / 4][8 * (3 - pos % 4) +: 8] = v;
  endfunction

  function automatic void restart_hash();
    chain_h[0] = 32'h67452301;
    chain_h[1] = 32'hefcdab89;
    chain_h[2] = 32'h98badcfe;
    chain_h[3] = 32'h10325476;
    chain_h[4] = 32'hc3d2e1f0;
    msg_len    = '0;
    blk_fill   = '0;
  endfunction

  // Pad, append the bit length, compress, and queue the five digest words
  function automatic void finish_hash();
    logic [63:0]  bit_len;
    int unsigned  pos;
    digest_word_t dw;
    bit_len = {msg_len, 3'b000};
    pos     = blk_fill;
    place_byte(pos, 8'h80);
    for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
    // No room left for the length: spill into a second block
    if (pos >= 56) begin
      compress_blk();
      for (int i = 0; i < 16; i++) msg_blk[i] = '0;
    end
    msg_blk[14] = bit_len[63:32];
    msg_blk[15] = bit_len[31:0];
    compress_blk();
    for (int i = 0; i < DigestWords; i++) begin
      dw.word  = chain_h[i];
      dw.index = 3'(i);
      dw.last  = (i == DigestWords - 1);
      digest_q.push_back(dw);
    end
    messages_done++;
    restart_hash();
  endfunction

  // Update the mirrored state for one accepted request
  function automatic void absorb_request(input logic [1:0] act, input logic [7:0] data);
    if (act == sha1_pkg::CMD_APPEND || act == sha1_pkg::CMD_APPEND_FINISH) begin
      place_byte(blk_fill, data);
      blk_fill++;
      msg_len++;
      if (blk_fill == 0) compress_blk();
    end
    if (act != sha1_pkg::CMD_APPEND) finish_hash();
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(input logic [1:0] act, input logic [7:0] data);
    int gap;
    gap = src_gaps_on ? random_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= act;
    req_if.data_byte <= data;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    absorb_request(act, data);
    requests_sent++;
  endtask

  // Send a message of len random bytes, closed by a random finish style
  task automatic send_message(input int len);
    int style;
    style = (len > 0) ? $urandom_range(0, 5) : $urandom_range(3, 5);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && style < 3) begin
        send_request(sha1_pkg::CMD_APPEND_FINISH, 8'($urandom));
      end else begin
        send_request(sha1_pkg::CMD_APPEND, 8'($urandom));
      end
    end
    if (style == 5) begin
      send_request(ActUnused, 8'($urandom));
    end else if (style >= 3) begin
      send_request(sha1_pkg::CMD_FINISH, 8'($urandom));
    end
  endtask

  // Drop valid, wait for every digest word, then let the core settle
  task automatic wait_for_digests();
    req_if.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_empty_message();
    send_request(sha1_pkg::CMD_FINISH, 8'hff);
    send_request(ActUnused, 8'h00);
    wait_for_digests();
  endtask

  task automatic test_short_messages();
    // "abc"
    send_request(sha1_pkg::CMD_APPEND, 8'h61);
    send_request(sha1_pkg::CMD_APPEND, 8'h62);
    send_request(sha1_pkg::CMD_APPEND_FINISH, 8'h63);
    // Byte extremes
    send_request(sha1_pkg::CMD_APPEND_FINISH, 8'h00);
    send_request(sha1_pkg::CMD_APPEND, 8'hff);
    send_request(sha1_pkg::CMD_APPEND, 8'h00);
    send_request(sha1_pkg::CMD_FINISH, 8'h5a);
    send_request(sha1_pkg::CMD_APPEND, 8'hff);
    send_request(ActUnused, 8'ha5);
    wait_for_digests();
  endtask

  // Hold off the digest side long enough that the request queue backs up
  task automatic test_digest_backpressure();
    src_gaps_on  = 1'b0;
    hold_request = 600;
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) begin
        send_request(sha1_pkg::CMD_FINISH, 8'($urandom));
      end else begin
        send_request(sha1_pkg::CMD_APPEND_FINISH, 8'($urandom));
      end
    end
    src_gaps_on = 1'b1;
    wait_for_digests();
  endtask

  // Lengths around the pad and block limits
  task automatic test_block_boundaries();
    int lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) begin
      src_gaps_on = $urandom_range(0, 3) != 0;
      send_message(lens[i]);
    end
    src_gaps_on = 1'b1;
    wait_for_digests();
  endtask

  task automatic test_random_messages();
    int start;
    int r;
    start = requests_sent;
    while (requests_sent - start < 110) begin
      src_gaps_on = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_message($urandom_range(0, 8));
      end else if (r < 85) begin
        send_message($urandom_range(9, 30));
      end else begin
        send_message($urandom_range(50, 70));
      end
    end
    src_gaps_on = 1'b1;
    wait_for_digests();
  endtask

  // Digest side: check each accepted word, drive ready with random stalls
  initial begin : digest_sink
    int           stall_left;
    int           mode_left;
    bit           sink_gaps_on;
    digest_word_t want;
    stall_left   = 0;
    mode_left    = 0;
    sink_gaps_on = 1'b1;
    dig_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && dig_if.valid === 1'b1 && dig_if.ready === 1'b1) begin
        if (digest_q.size() == 0) begin
          $error("digest word %h with no message finished", dig_if.digest_word);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          words_checked++;
          if (dig_if.digest_word !== want.word) begin
            $error("digest_word: expected %h, got %h", want.word, dig_if.digest_word);
            fail_count++;
          end
          if (dig_if.word_index !== want.index) begin
            $error("word_index: expected %0d, got %0d", want.index, dig_if.word_index);
            fail_count++;
          end
          if (dig_if.last_word !== want.last) begin
            $error("last_word: expected %0b, got %0b", want.last, dig_if.last_word);
            fail_count++;
          end
        end
      end
      // Switch between stalling and stall-free stretches
      if (mode_left == 0) begin
        sink_gaps_on = $urandom_range(0, 2) != 0;
        mode_left    = $urandom_range(50, 250);
      end else begin
        mode_left--;
      end
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        dig_if.ready <= 1'b0;
        stall_left--;
      end else begin
        dig_if.ready <= 1'b1;
        if (sink_gaps_on) stall_left = random_gap();
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : run_tests
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.action    <= sha1_pkg::CMD_APPEND;
    req_if.data_byte <= 8'h00;
    for (int i = 0; i < 16; i++) msg_blk[i] = '0;
    restart_hash();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_short_messages();
    test_digest_backpressure();
    test_block_boundaries();
    test_random_messages();

    $display("Sent %0d requests forming %0d messages, checked %0d digest words.",
             requests_sent, messages_done, words_checked);
    $display("Covered empty messages, code 3, pad limits at 55-64 bytes, a long digest stall.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
